/* hw/rtl/tngen_pkg.sv */
// Shared types, constants and helper functions of the tangent and normal generator.
`default_nettype none

package tngen_pkg;

    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_NORMALS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_UV      = 2'd1;

    localparam logic signed [31:0] Q_ONE   = 32'sd65536;
    localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] pz;
        logic signed [31:0] tu;
        logic signed [31:0] tv;
        logic signed [31:0] nx;
        logic signed [31:0] ny;
        logic signed [31:0] nz;
    } vtx_t;

    // Vertex 0 is the newest input, vertex 2 the oldest.
    typedef struct packed {
        vtx_t [2:0] v;
        logic       np;
        logic       uvp;
    } tri_t;

    typedef struct packed {
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [31:0] out_z;
        logic signed [31:0] out_u;
        logic signed [31:0] out_v;
        logic signed [31:0] normal_x;
        logic signed [31:0] normal_y;
        logic signed [31:0] normal_z;
        logic signed [31:0] tangent_x;
        logic signed [31:0] tangent_y;
        logic signed [31:0] tangent_z;
        logic               last_of_triangle;
    } res_t;

    function automatic logic signed [31:0] sat32(input logic signed [33:0] x);
        logic signed [31:0] r;
        if (x > 34'(S32_MAX))
            r = S32_MAX;
        else if (x < 34'(S32_MIN))
            r = S32_MIN;
        else
            r = x[31:0];
        return r;
    endfunction

    function automatic logic signed [31:0] flip_v(input logic signed [31:0] tv);
        return sat32(34'(Q_ONE) - 34'(tv));
    endfunction

    function automatic logic signed [31:0] sat_diff(input logic signed [31:0] a,
                                                    input logic signed [31:0] b);
        return sat32(34'(a) - 34'(b));
    endfunction

    function automatic logic signed [31:0] get_p(input vtx_t v, input logic [1:0] c);
        logic signed [31:0] r;
        unique case (c)
            2'd0:    r = v.px;
            2'd1:    r = v.py;
            default: r = v.pz;
        endcase
        return r;
    endfunction

    function automatic logic signed [31:0] get_n(input vtx_t v, input logic [1:0] c);
        logic signed [31:0] r;
        unique case (c)
            2'd0:    r = v.nx;
            2'd1:    r = v.ny;
            default: r = v.nz;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/triangle_normal_tangent_gen_top.sv */
// Top level of the per-triangle tangent and face normal generator.
// Rate: the first two vertices of a triangle are taken one per cycle. The third queues
// the triangle for the back part, whose time per triangle is shortest when every vector
// to normalize is zero and is otherwise set by the bit-serial square root and divider.
// The three result items then leave one per cycle while pop is high.
// Reset clears the vertex count, both configuration registers and all sequencing state.
`default_nettype none

module triangle_normal_tangent_gen_top (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // Vertex input queue side.
    input  wire logic                            push,
    output logic                                 full,
    input  wire logic signed [31:0]              pos_x,
    input  wire logic signed [31:0]              pos_y,
    input  wire logic signed [31:0]              pos_z,
    input  wire logic signed [31:0]              tex_u,
    input  wire logic signed [31:0]              tex_v,
    input  wire logic signed [31:0]              norm_in_x,
    input  wire logic signed [31:0]              norm_in_y,
    input  wire logic signed [31:0]              norm_in_z,
    // Result queue side.
    output logic                                 empty,
    input  wire logic                            pop,
    output logic signed [31:0]                   out_x,
    output logic signed [31:0]                   out_y,
    output logic signed [31:0]                   out_z,
    output logic signed [31:0]                   out_u,
    output logic signed [31:0]                   out_v,
    output logic signed [31:0]                   normal_x,
    output logic signed [31:0]                   normal_y,
    output logic signed [31:0]                   normal_z,
    output logic signed [31:0]                   tangent_x,
    output logic signed [31:0]                   tangent_y,
    output logic signed [31:0]                   tangent_z,
    output logic                                 last_of_triangle,
    // Configuration write channel.
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [tngen_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic                            cfg_data
);
    import tngen_pkg::*;

    vtx_t vin;
    tri_t q_wdata;
    tri_t q_rdata;
    res_t res;
    logic q_push;
    logic q_full;
    logic q_pop;
    logic q_empty;

    // Registers are plain flops, so a write is always taken at once.
    assign cfg_ready = 1'b1;

    assign vin.px = pos_x;
    assign vin.py = pos_y;
    assign vin.pz = pos_z;
    assign vin.tu = tex_u;
    assign vin.tv = tex_v;
    assign vin.nx = norm_in_x;
    assign vin.ny = norm_in_y;
    assign vin.nz = norm_in_z;

    // The front part holds the first two vertices and packs the whole triangle,
    // together with the configuration in force at its third vertex.
    tngen_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .vin       (vin),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_push    (q_push),
        .q_full    (q_full),
        .q_data    (q_wdata)
    );

    // Two triangles can wait here while the back part is busy.
    tngen_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_wdata),
        .full  (q_full),
        .pop   (q_pop),
        .rdata (q_rdata),
        .empty (q_empty)
    );

    // The back part works out normals and tangent and emits the vertices newest first.
    tngen_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .q_empty(q_empty),
        .q_pop  (q_pop),
        .q_head (q_rdata),
        .pop    (pop),
        .empty  (empty),
        .res    (res)
    );

    assign out_x            = res.out_x;
    assign out_y            = res.out_y;
    assign out_z            = res.out_z;
    assign out_u            = res.out_u;
    assign out_v            = res.out_v;
    assign normal_x         = res.normal_x;
    assign normal_y         = res.normal_y;
    assign normal_z         = res.normal_z;
    assign tangent_x        = res.tangent_x;
    assign tangent_y        = res.tangent_y;
    assign tangent_z        = res.tangent_z;
    assign last_of_triangle = res.last_of_triangle;

endmodule

`default_nettype wire

/* hw/rtl/tngen_queue.sv */
// Two-entry triangle queue between the front and back parts.
`default_nettype none

module tngen_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  tngen_pkg::tri_t     wdata,
    output logic                full,
    input  wire logic           pop,
    output tngen_pkg::tri_t     rdata,
    output logic                empty
);
    import tngen_pkg::*;

    tri_t                mem [QDEPTH];
    logic [QPTR_W-1:0]   wp_reg;
    logic [QPTR_W-1:0]   rp_reg;
    logic [QPTR_W:0]     cnt_reg;
    logic                do_push;
    logic                do_pop;

    assign full    = (cnt_reg == (QPTR_W+1)'(QDEPTH));
    assign empty   = (cnt_reg == '0);
    assign rdata   = mem[rp_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (do_push)
                wp_reg <= (wp_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wp_reg + 1'b1;
            if (do_pop)
                rp_reg <= (rp_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rp_reg + 1'b1;
            if (do_push && !do_pop)
                cnt_reg <= cnt_reg + 1'b1;
            else if (do_pop && !do_push)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wp_reg] <= wdata;
    end

endmodule

`default_nettype wire

/* hw/rtl/tngen_front.sv */
// Front part: configuration registers, vertex gathering and triangle assembly.
`default_nettype none

module tngen_front (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          push,
    output logic                               full,
    input  tngen_pkg::vtx_t                    vin,
    input  wire logic                          cfg_valid,
    input  wire logic [tngen_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic                          cfg_data,
    output logic                               q_push,
    input  wire logic                          q_full,
    output tngen_pkg::tri_t                    q_data
);
    import tngen_pkg::*;

    logic [1:0] count_reg;
    vtx_t       hold_reg [2];
    logic       np_reg;
    logic       uvp_reg;
    logic       accept;

    // Only the triangle-closing vertex needs room in the queue.
    assign full   = (count_reg == 2'd2) && q_full;
    assign accept = push && !full;
    assign q_push = accept && (count_reg == 2'd2);

    assign q_data.v[0] = vin;
    assign q_data.v[1] = hold_reg[1];
    assign q_data.v[2] = hold_reg[0];
    assign q_data.np   = np_reg;
    assign q_data.uvp  = uvp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
            np_reg    <= 1'b0;
            uvp_reg   <= 1'b0;
        end
        else
        begin
            if (accept)
                count_reg <= (count_reg == 2'd2) ? 2'd0 : count_reg + 2'd1;
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    REG_NORMALS: np_reg  <= cfg_data;
                    REG_UV:      uvp_reg <= cfg_data;
                    default:     ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && (count_reg != 2'd2))
            hold_reg[count_reg[0]] <= vin;
    end

endmodule

`default_nettype wire

/* hw/rtl/tngen_div.sv */
// Restoring divider, one quotient bit per cycle, 32 quotient bits.
`default_nettype none

module tngen_div (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [79:0] n,
    input  wire logic [63:0] d,
    output logic             done,
    output logic [31:0]      q,
    output logic [63:0]      r
);
    logic [63:0] rem_reg;
    logic [31:0] low_reg;
    logic [31:0] q_reg;
    logic [63:0] d_reg;
    logic [4:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [64:0] trial;
    logic [64:0] sub;
    logic        ge;

    // The caller guarantees that the upper dividend bits are below the divisor.
    assign trial = {rem_reg, low_reg[31]};
    assign sub   = trial - {1'b0, d_reg};
    assign ge    = (trial >= {1'b0, d_reg});
    assign done  = done_reg;
    assign q     = q_reg;
    assign r     = rem_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == 5'd31)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= {16'b0, n[79:32]};
            low_reg <= n[31:0];
            d_reg   <= d;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? sub[63:0] : trial[63:0];
            low_reg <= {low_reg[30:0], 1'b0};
            q_reg   <= {q_reg[30:0], ge};
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/tngen_sqrt.sv */
// Integer square root of a 64-bit value, one result bit per cycle.
`default_nettype none

module tngen_sqrt (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [63:0] x,
    output logic             done,
    output logic [31:0]      root
);
    logic [63:0] x_reg;
    logic [63:0] res_reg;
    logic [63:0] bit_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [63:0] trial;

    assign trial = res_reg + bit_reg;
    assign done  = done_reg;
    assign root  = res_reg[31:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
                busy_reg <= 1'b1;
            else if (busy_reg && bit_reg[0])
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg   <= x;
            res_reg <= '0;
            bit_reg <= 64'h4000_0000_0000_0000;
        end
        else if (busy_reg)
        begin
            if (x_reg >= trial)
            begin
                x_reg   <= x_reg - trial;
                res_reg <= (res_reg >> 1) + bit_reg;
            end
            else
                res_reg <= res_reg >> 1;
            bit_reg <= bit_reg >> 2;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/tngen_back.sv */
// Back part: normals, face normal, tangent and the three result items per triangle.
`default_nettype none

module tngen_back (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       q_empty,
    output logic            q_pop,
    input  tngen_pkg::tri_t q_head,
    input  wire logic       pop,
    output logic            empty,
    output tngen_pkg::res_t res
);
    import tngen_pkg::*;

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_N_ABS   = 4'd1;
    localparam logic [3:0] S_N_SHIFT = 4'd2;
    localparam logic [3:0] S_N_SQ    = 4'd3;
    localparam logic [3:0] S_N_SQRT  = 4'd4;
    localparam logic [3:0] S_N_SQW   = 4'd5;
    localparam logic [3:0] S_N_DIV   = 4'd6;
    localparam logic [3:0] S_N_DIVW  = 4'd7;
    localparam logic [3:0] S_CROSS   = 4'd8;
    localparam logic [3:0] S_T_MUL   = 4'd9;
    localparam logic [3:0] S_T_DIV   = 4'd10;
    localparam logic [3:0] S_T_DIVW  = 4'd11;
    localparam logic [3:0] S_OUT     = 4'd12;

    logic [3:0]          state_reg, state_next;
    logic [1:0]          job_reg, job_next;
    logic [3:0]          cnt_reg, cnt_next;
    logic [1:0]          k_reg, k_next;
    tri_t                tri_reg, tri_next;
    logic [33:0]         m_reg [3];
    logic [33:0]         m_next [3];
    logic [33:0]         mx_reg, mx_next;
    logic                sgn_reg [3];
    logic                sgn_next [3];
    logic [63:0]         sum_reg, sum_next;
    logic [31:0]         len_reg, len_next;
    logic signed [17:0]  nv_reg [3][3];
    logic signed [17:0]  nv_next [3][3];
    logic signed [18:0]  face_reg [3];
    logic signed [18:0]  face_next [3];
    logic signed [65:0]  acc_reg, acc_next;
    logic signed [65:0]  prod_reg, prod_next;
    logic signed [63:0]  det_reg, det_next;
    logic signed [63:0]  num_reg [3];
    logic signed [63:0]  num_next [3];
    logic signed [31:0]  tan_reg [3];
    logic signed [31:0]  tan_next [3];
    logic                tneg_reg, tneg_next;

    logic                last_job;
    logic [3:0]          after_norm;
    logic [1:0]          src_sel;
    logic signed [33:0]  vec [3];
    logic [33:0]         vabs [3];
    logic [33:0]         vmax;
    logic [30:0]         msel;
    logic signed [32:0]  mul_a, mul_b;
    logic signed [65:0]  diff;
    logic [2:0]          idx;
    logic signed [34:0]  cdiff;
    logic [34:0]         cmag;
    logic [17:0]         cround;
    logic signed [31:0]  d1u, d1v, d2u, d2v;
    logic signed [31:0]  e1 [3];
    logic signed [31:0]  e2 [3];
    logic signed [63:0]  tnum;
    logic [63:0]         nm, dm;
    logic                t_big;
    logic                rnd;
    logic [32:0]         qr;
    logic                div_start, div_done;
    logic [79:0]         div_n;
    logic [63:0]         div_d;
    logic [31:0]         div_q;
    logic [63:0]         div_r;
    logic                sq_start, sq_done;
    logic [31:0]         sq_root;
    vtx_t                ov;

    tngen_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .n     (div_n),
        .d     (div_d),
        .done  (div_done),
        .q     (div_q),
        .r     (div_r)
    );

    tngen_sqrt u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sq_start),
        .x     (sum_reg),
        .done  (sq_done),
        .root  (sq_root)
    );

    // Vector to normalize: a supplied normal, or an edge from the newest vertex.
    assign last_job = tri_reg.np ? (job_reg == 2'd2) : (job_reg == 2'd1);
    assign src_sel  = (job_reg == 2'd0) ? 2'd2 : 2'd1;

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            if (tri_reg.np)
                vec[c] = 34'(get_n(tri_reg.v[job_reg], 2'(c)));
            else
                vec[c] = 34'(get_p(tri_reg.v[0], 2'(c)))
                       - 34'(get_p(tri_reg.v[src_sel], 2'(c)));
            vabs[c] = vec[c][33] ? 34'(-vec[c]) : 34'(vec[c]);
        end
        vmax = vabs[0];
        if (vabs[1] > vmax)
            vmax = vabs[1];
        if (vabs[2] > vmax)
            vmax = vabs[2];
    end

    // Texture and edge differences for the tangent, taken from flipped v.
    always_comb
    begin
        d1u = sat_diff(tri_reg.v[1].tu, tri_reg.v[0].tu);
        d2u = sat_diff(tri_reg.v[2].tu, tri_reg.v[0].tu);
        d1v = sat_diff(flip_v(tri_reg.v[1].tv), flip_v(tri_reg.v[0].tv));
        d2v = sat_diff(flip_v(tri_reg.v[2].tv), flip_v(tri_reg.v[0].tv));
        for (int c = 0; c < 3; c++)
        begin
            e1[c] = sat_diff(get_p(tri_reg.v[1], 2'(c)), get_p(tri_reg.v[0], 2'(c)));
            e2[c] = sat_diff(get_p(tri_reg.v[2], 2'(c)), get_p(tri_reg.v[0], 2'(c)));
        end
    end

    // Shared multiplier operand selection.
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        msel  = '0;
        if (state_reg == S_N_SQ)
        begin
            unique case (cnt_reg[1:0])
                2'd0:    msel = m_reg[0][30:0];
                2'd1:    msel = m_reg[1][30:0];
                2'd2:    msel = m_reg[2][30:0];
                default: msel = '0;
            endcase
            mul_a = $signed({2'b0, msel});
            mul_b = $signed({2'b0, msel});
        end
        else if (state_reg == S_CROSS)
        begin
            unique case (cnt_reg)
                4'd0:    begin mul_a = 33'(nv_reg[0][1]); mul_b = 33'(nv_reg[1][2]); end
                4'd1:    begin mul_a = 33'(nv_reg[0][2]); mul_b = 33'(nv_reg[1][1]); end
                4'd2:    begin mul_a = 33'(nv_reg[0][2]); mul_b = 33'(nv_reg[1][0]); end
                4'd3:    begin mul_a = 33'(nv_reg[0][0]); mul_b = 33'(nv_reg[1][2]); end
                4'd4:    begin mul_a = 33'(nv_reg[0][0]); mul_b = 33'(nv_reg[1][1]); end
                4'd5:    begin mul_a = 33'(nv_reg[0][1]); mul_b = 33'(nv_reg[1][0]); end
                default: ;
            endcase
        end
        else if (state_reg == S_T_MUL)
        begin
            unique case (cnt_reg)
                4'd0:    begin mul_a = 33'(d1u); mul_b = 33'(d2v);   end
                4'd1:    begin mul_a = 33'(d1v); mul_b = 33'(d2u);   end
                4'd2:    begin mul_a = 33'(d2v); mul_b = 33'(e1[0]); end
                4'd3:    begin mul_a = 33'(d1v); mul_b = 33'(e2[0]); end
                4'd4:    begin mul_a = 33'(d2v); mul_b = 33'(e1[1]); end
                4'd5:    begin mul_a = 33'(d1v); mul_b = 33'(e2[1]); end
                4'd6:    begin mul_a = 33'(d2v); mul_b = 33'(e1[2]); end
                4'd7:    begin mul_a = 33'(d1v); mul_b = 33'(e2[2]); end
                default: ;
            endcase
        end
    end

    assign prod_next = mul_a * mul_b;
    assign diff      = acc_reg - prod_reg;
    assign idx       = 3'(cnt_reg - 4'd1);

    // Cross product term, rounded from Q32 to Q16 half away from zero.
    assign cdiff  = diff[34:0];
    assign cmag   = cdiff[34] ? 35'(-cdiff) : 35'(cdiff);
    assign cround = 18'((cmag + 35'd32768) >> 16);

    // Tangent division operands.
    assign tnum  = num_reg[cnt_reg[1:0]];
    assign nm    = tnum[63] ? 64'(-tnum) : 64'(tnum);
    assign dm    = det_reg[63] ? 64'(-det_reg) : 64'(det_reg);
    assign t_big = ({16'b0, nm} >= {dm, 16'b0});
    assign rnd   = ({div_r, 1'b0} >= {1'b0, dm});
    assign qr    = {1'b0, div_q} + 33'(rnd);

    // Where the sequence goes once the current normalization is finished.
    always_comb
    begin
        if (!last_job)
            after_norm = S_N_ABS;
        else if (!tri_reg.np)
            after_norm = S_CROSS;
        else if (tri_reg.uvp)
            after_norm = S_T_MUL;
        else
            after_norm = S_OUT;
    end

    always_comb
    begin
        state_next = state_reg;
        job_next   = job_reg;
        cnt_next   = cnt_reg;
        k_next     = k_reg;
        tri_next   = tri_reg;
        mx_next    = mx_reg;
        sum_next   = sum_reg;
        len_next   = len_reg;
        acc_next   = acc_reg;
        det_next   = det_reg;
        tneg_next  = tneg_reg;
        for (int c = 0; c < 3; c++)
        begin
            m_next[c]    = m_reg[c];
            sgn_next[c]  = sgn_reg[c];
            face_next[c] = face_reg[c];
            num_next[c]  = num_reg[c];
            tan_next[c]  = tan_reg[c];
            for (int j = 0; j < 3; j++)
                nv_next[j][c] = nv_reg[j][c];
        end
        q_pop     = 1'b0;
        div_start = 1'b0;
        div_n     = '0;
        div_d     = '0;
        sq_start  = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop    = 1'b1;
                    tri_next = q_head;
                    job_next = 2'd0;
                    k_next   = 2'd0;
                    cnt_next = '0;
                    if (q_head.np || !q_head.uvp)
                        state_next = q_head.np ? S_N_ABS : S_N_ABS;
                    else
                        state_next = S_N_ABS;
                end
            end
            S_N_ABS:
            begin
                for (int c = 0; c < 3; c++)
                begin
                    m_next[c]   = vabs[c];
                    sgn_next[c] = vec[c][33];
                end
                mx_next = vmax;
                if (vmax == '0)
                begin
                    for (int c = 0; c < 3; c++)
                        nv_next[job_reg][c] = '0;
                    job_next   = job_reg + 2'd1;
                    cnt_next   = '0;
                    state_next = after_norm;
                end
                else
                    state_next = S_N_SHIFT;
            end
            S_N_SHIFT:
            begin
                // Bring the largest magnitude into [2^30, 2^31).
                if (mx_reg[33:31] != 3'b000)
                begin
                    mx_next = mx_reg >> 1;
                    for (int c = 0; c < 3; c++)
                        m_next[c] = m_reg[c] >> 1;
                end
                else if (!mx_reg[30])
                begin
                    mx_next = mx_reg << 1;
                    for (int c = 0; c < 3; c++)
                        m_next[c] = m_reg[c] << 1;
                end
                else
                begin
                    sum_next   = '0;
                    cnt_next   = '0;
                    state_next = S_N_SQ;
                end
            end
            S_N_SQ:
            begin
                if (cnt_reg != '0)
                    sum_next = sum_reg + prod_reg[63:0];
                cnt_next = cnt_reg + 4'd1;
                if (cnt_reg == 4'd3)
                    state_next = S_N_SQRT;
            end
            S_N_SQRT:
            begin
                sq_start   = 1'b1;
                state_next = S_N_SQW;
            end
            S_N_SQW:
            begin
                if (sq_done)
                begin
                    len_next   = sq_root;
                    cnt_next   = '0;
                    state_next = S_N_DIV;
                end
            end
            S_N_DIV:
            begin
                div_start  = 1'b1;
                div_n      = 80'({m_reg[cnt_reg[1:0]][30:0], 16'b0})
                           + 80'(len_reg >> 1);
                div_d      = {32'b0, len_reg};
                state_next = S_N_DIVW;
            end
            S_N_DIVW:
            begin
                if (div_done)
                begin
                    nv_next[job_reg][cnt_reg[1:0]] = sgn_reg[cnt_reg[1:0]]
                        ? -$signed({1'b0, div_q[16:0]})
                        : $signed({1'b0, div_q[16:0]});
                    if (cnt_reg == 4'd2)
                    begin
                        job_next   = job_reg + 2'd1;
                        cnt_next   = '0;
                        state_next = after_norm;
                    end
                    else
                    begin
                        cnt_next   = cnt_reg + 4'd1;
                        state_next = S_N_DIV;
                    end
                end
            end
            S_CROSS:
            begin
                if (cnt_reg != '0)
                begin
                    if (!idx[0])
                        acc_next = prod_reg;
                    else
                        face_next[idx[2:1]] = cdiff[34] ? -$signed({1'b0, cround})
                                                        : $signed({1'b0, cround});
                end
                cnt_next = cnt_reg + 4'd1;
                if (cnt_reg == 4'd6)
                begin
                    cnt_next   = '0;
                    state_next = tri_reg.uvp ? S_T_MUL : S_OUT;
                end
            end
            S_T_MUL:
            begin
                if (cnt_reg != '0)
                begin
                    if (!idx[0])
                        acc_next = prod_reg;
                    else if (idx[2:1] == 2'd0)
                        det_next = diff[63:0];
                    else
                        num_next[2'(idx[2:1] - 2'd1)] = diff[63:0];
                end
                cnt_next = cnt_reg + 4'd1;
                if (cnt_reg == 4'd8)
                begin
                    cnt_next   = '0;
                    state_next = S_T_DIV;
                end
            end
            S_T_DIV:
            begin
                tneg_next = tnum[63] ^ det_reg[63];
                if ((det_reg == '0) || t_big)
                begin
                    if (det_reg == '0)
                        tan_next[cnt_reg[1:0]] = (tnum > 0) ? S32_MAX :
                                                 (tnum < 0) ? S32_MIN : '0;
                    else
                        tan_next[cnt_reg[1:0]] = (tnum[63] ^ det_reg[63]) ? S32_MIN
                                                                           : S32_MAX;
                    if (cnt_reg == 4'd2)
                        state_next = S_OUT;
                    else
                        cnt_next = cnt_reg + 4'd1;
                end
                else
                begin
                    div_start  = 1'b1;
                    div_n      = {nm, 16'b0};
                    div_d      = dm;
                    state_next = S_T_DIVW;
                end
            end
            S_T_DIVW:
            begin
                if (div_done)
                begin
                    if (tneg_reg)
                        tan_next[cnt_reg[1:0]] = (qr > 33'h0_8000_0000) ? S32_MIN
                                                                        : 32'(-qr);
                    else
                        tan_next[cnt_reg[1:0]] = (qr > 33'h0_7FFF_FFFF) ? S32_MAX
                                                                        : qr[31:0];
                    if (cnt_reg == 4'd2)
                        state_next = S_OUT;
                    else
                    begin
                        cnt_next   = cnt_reg + 4'd1;
                        state_next = S_T_DIV;
                    end
                end
            end
            S_OUT:
            begin
                if (pop)
                begin
                    if (k_reg == 2'd2)
                        state_next = S_IDLE;
                    else
                        k_next = k_reg + 2'd1;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            job_reg   <= 2'd0;
            cnt_reg   <= '0;
            k_reg     <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            job_reg   <= job_next;
            cnt_reg   <= cnt_next;
            k_reg     <= k_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tri_reg  <= tri_next;
        mx_reg   <= mx_next;
        sum_reg  <= sum_next;
        len_reg  <= len_next;
        acc_reg  <= acc_next;
        prod_reg <= prod_next;
        det_reg  <= det_next;
        tneg_reg <= tneg_next;
        for (int c = 0; c < 3; c++)
        begin
            m_reg[c]    <= m_next[c];
            sgn_reg[c]  <= sgn_next[c];
            face_reg[c] <= face_next[c];
            num_reg[c]  <= num_next[c];
            tan_reg[c]  <= tan_next[c];
            for (int j = 0; j < 3; j++)
                nv_reg[j][c] <= nv_next[j][c];
        end
    end

    // Result item k, taken from the finished triangle.
    assign empty = (state_reg != S_OUT);
    assign ov    = tri_reg.v[k_reg];

    always_comb
    begin
        res.out_x            = ov.px;
        res.out_y            = ov.py;
        res.out_z            = ov.pz;
        res.out_u            = tri_reg.uvp ? ov.tu : '0;
        res.out_v            = tri_reg.uvp ? flip_v(ov.tv) : '0;
        res.normal_x         = tri_reg.np ? 32'(nv_reg[k_reg][0]) : 32'(face_reg[0]);
        res.normal_y         = tri_reg.np ? 32'(nv_reg[k_reg][1]) : 32'(face_reg[1]);
        res.normal_z         = tri_reg.np ? 32'(nv_reg[k_reg][2]) : 32'(face_reg[2]);
        res.tangent_x        = tri_reg.uvp ? tan_reg[0] : Q_ONE;
        res.tangent_y        = tri_reg.uvp ? tan_reg[1] : '0;
        res.tangent_z        = tri_reg.uvp ? tan_reg[2] : '0;
        res.last_of_triangle = (k_reg == 2'd2);
    end

endmodule

`default_nettype wire
